// ===== sv/cgcl_pkg.sv =====
// ----------------------------------------------------------------------------
// cgcl_pkg: shared types and codes of the cylindrical grid cell locator
// Command codes, register indexes, the sequencer state type and the control
// bundles that the sequencer hands to the width cells and the search unit.
// ----------------------------------------------------------------------------
package cgcl_pkg;

  // command codes carried in the input tuser
  localparam logic [1:0] CMD_LOAD_RADIAL = 2'd0;
  localparam logic [1:0] CMD_LOAD_AXIAL  = 2'd1;
  localparam logic [1:0] CMD_LOCATE      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_RADIAL_CELLS = 2'd0;
  localparam logic [1:0] REG_AXIAL_CELLS  = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE   = 2'd2;

  // configuration reset values
  localparam logic [8:0] RADIAL_CELLS_RST = 9'd256;
  localparam logic [8:0] AXIAL_CELLS_RST  = 9'd256;
  localparam logic [8:0] ROW_STRIDE_RST   = 9'd258;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_WALK,
    ST_DRAIN0,
    ST_DRAIN1,
    ST_FIN
  } state_t;

  // control of the width cells
  typedef struct packed {
    logic        shift;
    logic        wr_radial;
    logic        wr_axial;
    logic [7:0]  wr_index;
    logic [31:0] wr_data;
  } cell_ctrl_t;

  // control of the search unit
  typedef struct packed {
    logic sq_x;
    logic sq_y;
    logic sq_sum;
    logic clear;
    logic step;
    logic take_r;
    logic take_a;
  } srch_ctrl_t;

endpackage

// ===== sv/cgcl_cell.sv =====
// ----------------------------------------------------------------------------
// cgcl_cell: one position of the rotating width chain
// Holds one radial and one axial width. Loads its own entry when idle and
// takes its neighbor's widths on every shift of a locate walk.
// ----------------------------------------------------------------------------
module cgcl_cell #(
  parameter int unsigned K     = 0,
  parameter bit          HAS_R = 1'b1,
  parameter bit          HAS_A = 1'b1
) (
  input  logic                  clk,
  input  cgcl_pkg::cell_ctrl_t  ctrl,
  input  logic [31:0]           nb_radial,
  input  logic [31:0]           nb_axial,
  output logic [31:0]           radial_w,
  output logic [31:0]           axial_w
);

  logic hit;

  // entry select for loads
  assign hit = (32'(ctrl.wr_index) == 32'(K));

  // width storage, rotating during a walk
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      radial_w <= nb_radial;
      axial_w  <= nb_axial;
    end else begin
      if (HAS_R && ctrl.wr_radial && hit) begin
        radial_w <= ctrl.wr_data;
      end
      if (HAS_A && ctrl.wr_axial && hit) begin
        axial_w <= ctrl.wr_data;
      end
    end
  end

endmodule

// ===== sv/cgcl_search.sv =====
// ----------------------------------------------------------------------------
// cgcl_search: radius squaring and running-sum search
// Squares |x| and |y| through one shared multiplier, then follows the widths
// leaving the head of the chain: running sums, squared radial sum, and the
// first cell whose sum passes the point, radially and axially.
// ----------------------------------------------------------------------------
module cgcl_search #(
  parameter int NCELL = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cgcl_pkg::srch_ctrl_t         ctrl,
  input  logic [$clog2(NCELL)-1:0]     tag,
  input  logic [31:0]                  ax,
  input  logic [31:0]                  ay,
  input  logic [30:0]                  z_mag,
  input  logic [31:0]                  head_radial,
  input  logic [31:0]                  head_axial,
  output logic                         found_r,
  output logic                         found_a,
  output logic [$clog2(NCELL)-1:0]     rad_idx,
  output logic [$clog2(NCELL)-1:0]     ax_idx
);

  localparam int IW   = $clog2(NCELL);
  localparam int SUMW = 32 + $clog2(NCELL);

  logic [31:0]     mul_op;
  logic [63:0]     mul_res;
  logic [63:0]     prod;
  logic [63:0]     r2;
  logic [SUMW-1:0] sum_r;
  logic [SUMW-1:0] sum_a;
  logic            va_r;
  logic            va_a;
  logic [IW-1:0]   tag_a;
  logic            vb;
  logic            big_b;
  logic [IW-1:0]   tag_b;

  // shared squarer
  assign mul_op  = ctrl.sq_x ? ax : (ctrl.sq_y ? ay : sum_r[31:0]);
  assign mul_res = mul_op * mul_op;

  always_ff @(posedge clk) begin
    prod <= mul_res;
  end

  // radius squared from the two squares
  always_ff @(posedge clk) begin
    if (ctrl.sq_y) begin
      r2 <= prod;
    end else if (ctrl.sq_sum) begin
      r2 <= r2 + prod;
    end
  end

  // stage a: running sums of the widths at the chain head
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum_r <= '0;
      sum_a <= '0;
    end else if (ctrl.step) begin
      sum_r <= sum_r + SUMW'(head_radial);
      sum_a <= sum_a + SUMW'(head_axial);
    end
    tag_a <= tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va_r <= 1'b0;
      va_a <= 1'b0;
      vb   <= 1'b0;
    end else begin
      va_r <= ctrl.step && ctrl.take_r;
      va_a <= ctrl.step && ctrl.take_a;
      vb   <= va_r;
    end
  end

  // stage b: square of the radial sum alongside its tag
  always_ff @(posedge clk) begin
    big_b <= |sum_r[SUMW-1:32];
    tag_b <= tag_a;
  end

  // first axial sum above z
  always_ff @(posedge clk) begin
    if (rst) begin
      found_a <= 1'b0;
    end else if (ctrl.clear) begin
      found_a <= 1'b0;
    end else if (va_a && !found_a && (sum_a > SUMW'(z_mag))) begin
      found_a <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (va_a && !found_a && (sum_a > SUMW'(z_mag))) begin
      ax_idx <= tag_a;
    end
  end

  // stage c: first radial sum whose square passes r2
  always_ff @(posedge clk) begin
    if (rst) begin
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      found_r <= 1'b0;
    end else if (vb && !found_r && (big_b || (prod > r2))) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vb && !found_r && (big_b || (prod > r2))) begin
      rad_idx <= tag_b;
    end
  end

endmodule

// ===== sv/cylindrical_grid_cell_locator.sv =====
// ----------------------------------------------------------------------------
// cylindrical_grid_cell_locator: finds the cylindrical grid cell of a point
// Width tables live in a rotating chain of cells; a locate walks the whole
// chain past one search unit that keeps running sums and compares squares.
// ----------------------------------------------------------------------------
// load commands are written while idle; a locate steps from accept to result
// through SQX, SQY, SUM, WALK, DRAIN0, DRAIN1 and FIN, its WALK passing all
// NCELL = max(MAX_RADIAL, MAX_AXIAL) width cells past the chain head, one
// cell per cycle; one item is worked on at a time: loads every cycle while
// idle, none during a locate; a waiting result does not block loads
// reset (rst, synchronous) returns to idle and sets the cell counts to 256
// and the stride to 258; the width tables hold garbage until loaded
module cylindrical_grid_cell_locator #(
  parameter int MAX_RADIAL = 256,
  parameter int MAX_AXIAL  = 256
) (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_data,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // table_index, cell_width, x_pos, y_pos, z_pos
  input  logic [1:0]   s_tuser,   // command
  // result items
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // radial_index, axial_index, cell_number, zero pad
  output logic         m_tuser    // outside
);

  localparam int NCELL = (MAX_RADIAL > MAX_AXIAL) ? MAX_RADIAL : MAX_AXIAL;
  localparam int IW    = $clog2(NCELL);
  localparam int CNTW  = $clog2(NCELL + 1);
  localparam int NW    = (CNTW > 9) ? CNTW : 9;

  cgcl_pkg::state_t     state;
  cgcl_pkg::state_t     state_next;
  cgcl_pkg::cell_ctrl_t cell_ctrl;
  cgcl_pkg::srch_ctrl_t srch_ctrl;

  logic [8:0]    radial_cells;
  logic [8:0]    axial_cells;
  logic [8:0]    row_stride;
  logic          s_accept;
  logic          out_free;
  logic          out_load;
  logic [IW-1:0] cnt;
  logic          walk_end;
  logic [31:0]   x_pos;
  logic [31:0]   y_pos;
  logic [31:0]   ax;
  logic [31:0]   ay;
  logic [31:0]   z_pos;
  logic [NW-1:0] n_r;
  logic [NW-1:0] n_a;
  logic [IW-1:0] last_r;
  logic [IW-1:0] last_a;
  logic          found_r;
  logic          found_a;
  logic [IW-1:0] rad_idx;
  logic [IW-1:0] ax_idx;
  logic [IW-1:0] i_fin;
  logic [IW-1:0] j_fin;
  logic          outside_fin;
  logic [16:0]   cell_fin;
  logic [31:0]   rw [NCELL];
  logic [31:0]   aw [NCELL];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radial_cells <= cgcl_pkg::RADIAL_CELLS_RST;
      axial_cells  <= cgcl_pkg::AXIAL_CELLS_RST;
      row_stride   <= cgcl_pkg::ROW_STRIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cgcl_pkg::REG_RADIAL_CELLS: radial_cells <= cfg_data;
        cgcl_pkg::REG_AXIAL_CELLS:  axial_cells  <= cfg_data;
        cgcl_pkg::REG_ROW_STRIDE:   row_stride   <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell counts clamped to the table sizes
  assign n_r = (NW'(radial_cells) > NW'(MAX_RADIAL)) ? NW'(MAX_RADIAL) : NW'(radial_cells);
  assign n_a = (NW'(axial_cells) > NW'(MAX_AXIAL)) ? NW'(MAX_AXIAL) : NW'(axial_cells);
  assign last_r = (n_r == '0) ? '0 : IW'(n_r - NW'(1));
  assign last_a = (n_a == '0) ? '0 : IW'(n_a - NW'(1));

  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign walk_end = (cnt == IW'(NCELL - 1));

  // point capture with magnitudes of x and y
  assign x_pos = s_tdata[71:40];
  assign y_pos = s_tdata[103:72];

  always_ff @(posedge clk) begin
    if (s_accept) begin
      ax    <= x_pos[31] ? (~x_pos + 32'd1) : x_pos;
      ay    <= y_pos[31] ? (~y_pos + 32'd1) : y_pos;
      z_pos <= s_tdata[135:104];
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgcl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cgcl_pkg::ST_IDLE: begin
        if (s_accept && (s_tuser == cgcl_pkg::CMD_LOCATE)) begin
          state_next = cgcl_pkg::ST_SQX;
        end
      end
      cgcl_pkg::ST_SQX:    state_next = cgcl_pkg::ST_SQY;
      cgcl_pkg::ST_SQY:    state_next = cgcl_pkg::ST_SUM;
      cgcl_pkg::ST_SUM:    state_next = cgcl_pkg::ST_WALK;
      cgcl_pkg::ST_WALK: begin
        if (walk_end) begin
          state_next = cgcl_pkg::ST_DRAIN0;
        end
      end
      cgcl_pkg::ST_DRAIN0: state_next = cgcl_pkg::ST_DRAIN1;
      cgcl_pkg::ST_DRAIN1: state_next = cgcl_pkg::ST_FIN;
      cgcl_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = cgcl_pkg::ST_IDLE;
        end
      end
      default: state_next = cgcl_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready            = 1'b0;
    out_load            = 1'b0;
    cell_ctrl.shift     = 1'b0;
    cell_ctrl.wr_radial = 1'b0;
    cell_ctrl.wr_axial  = 1'b0;
    cell_ctrl.wr_index  = s_tdata[7:0];
    cell_ctrl.wr_data   = s_tdata[39:8];
    srch_ctrl           = '0;
    srch_ctrl.take_r    = (NW'(cnt) < n_r);
    srch_ctrl.take_a    = (NW'(cnt) < n_a);
    case (state)
      cgcl_pkg::ST_IDLE: begin
        s_tready            = 1'b1;
        cell_ctrl.wr_radial = s_tvalid && (s_tuser == cgcl_pkg::CMD_LOAD_RADIAL);
        cell_ctrl.wr_axial  = s_tvalid && (s_tuser == cgcl_pkg::CMD_LOAD_AXIAL);
      end
      cgcl_pkg::ST_SQX: srch_ctrl.sq_x = 1'b1;
      cgcl_pkg::ST_SQY: srch_ctrl.sq_y = 1'b1;
      cgcl_pkg::ST_SUM: begin
        srch_ctrl.sq_sum = 1'b1;
        srch_ctrl.clear  = 1'b1;
      end
      cgcl_pkg::ST_WALK: begin
        srch_ctrl.step  = 1'b1;
        cell_ctrl.shift = 1'b1;
      end
      cgcl_pkg::ST_FIN: out_load = out_free;
      default: ;
    endcase
  end

  // walk position, equal to the table entry now at the chain head
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == cgcl_pkg::ST_SUM) begin
      cnt <= '0;
    end else if (state == cgcl_pkg::ST_WALK) begin
      cnt <= cnt + IW'(1);
    end
  end

  // rotating chain of width cells, head at position zero
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    cgcl_cell #(
      .K     (k),
      .HAS_R (k < MAX_RADIAL),
      .HAS_A (k < MAX_AXIAL)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .nb_radial (rw[(k + 1) % NCELL]),
      .nb_axial  (aw[(k + 1) % NCELL]),
      .radial_w  (rw[k]),
      .axial_w   (aw[k])
    );
  end

  cgcl_search #(
    .NCELL (NCELL)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (srch_ctrl),
    .tag         (cnt),
    .ax          (ax),
    .ay          (ay),
    .z_mag       (z_pos[30:0]),
    .head_radial (rw[0]),
    .head_axial  (aw[0]),
    .found_r     (found_r),
    .found_a     (found_a),
    .rad_idx     (rad_idx),
    .ax_idx      (ax_idx)
  );

  // final indices, clamping and cell number
  assign i_fin       = found_r ? rad_idx : last_r;
  assign j_fin       = z_pos[31] ? '0 : (found_a ? ax_idx : last_a);
  assign outside_fin = !found_r || z_pos[31] || !found_a;
  assign cell_fin    = 17'(row_stride) * (17'(j_fin) + 17'd1) + 17'(i_fin) + 17'd1;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, cell_fin, 8'(j_fin), 8'(i_fin)};
      m_tuser <= outside_fin;
    end
  end

endmodule
